[rtl/lbp_pkg.sv]
// Shared types and constants for the LSB-first bit packer.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package lbp_pkg;

  localparam int WORD_BITS   = 32;
  localparam int CODE_BITS   = 64;
  localparam int COUNT_W     = 7;
  localparam int PCOUNT_W    = 5;
  localparam int VBITS_W     = 6;
  localparam int ACC_BITS    = CODE_BITS + WORD_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int S_TDATA_W   = 72;  // code_value, bit_count, zero padding
  localparam int M_TDATA_W   = 40;  // packed_word, valid_bits, zero padding

  localparam logic [COUNT_W-1:0] MAX_COUNT   = 7'd64;
  localparam logic [VBITS_W-1:0] FULL_VBITS  = 6'd32;

  // Command kinds carried in s_axis_tuser.
  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  // Classified item handed from the front to the back.
  typedef struct packed {
    cmd_e                  kind;
    logic [CODE_BITS-1:0]  bits;   // already masked to count
    logic [COUNT_W-1:0]    count;  // 0 to 64
  } item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[rtl/lbp_front.sv]
// Front end of the bit packer: saturates counts, masks code bits and drops
// appends of zero bits. Depends on lbp_pkg.
`default_nettype none

module lbp_front (
  input  wire logic                            s_valid_i,
  input  wire logic                            s_user_i,
  input  wire logic [lbp_pkg::CODE_BITS-1:0]   s_code_i,
  input  wire logic [lbp_pkg::COUNT_W-1:0]     s_count_i,
  output logic                                 s_ready_o,
  input  wire lbp_pkg::q_stat_t                q_stat_i,
  output logic                                 push_o,
  output lbp_pkg::item_t                       item_o
);
  import lbp_pkg::*;

  logic [COUNT_W-1:0]   sat_count;
  logic [CODE_BITS-1:0] mask;

  always_comb begin
    sat_count = (s_count_i > MAX_COUNT) ? MAX_COUNT : s_count_i;
    if (sat_count[COUNT_W-1]) begin
      mask = '1;
    end else begin
      mask = (CODE_BITS'(1) << sat_count[COUNT_W-2:0]) - CODE_BITS'(1);
    end
  end

  assign s_ready_o = !q_stat_i.full;

  always_comb begin
    item_o.kind  = cmd_e'(s_user_i);
    item_o.bits  = s_code_i & mask;
    item_o.count = sat_count;
  end

  // Drop appends that carry no bits; they never change the state.
  assign push_o = s_valid_i && !q_stat_i.full
                  && ((item_o.kind == CMD_FLUSH) || (sat_count != '0));

endmodule

`default_nettype wire

[rtl/lbp_queue.sv]
// Two-entry queue decoupling the packer front from its back end.
// Depends on lbp_pkg for the item type and depth constants.
`default_nettype none

module lbp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lbp_pkg::item_t   item_i,
  input  wire logic             pop_i,
  output lbp_pkg::item_t        item_o,
  output lbp_pkg::q_stat_t      stat_o
);
  import lbp_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lbp_back.sv]
// Back end of the bit packer: holds the pending bits, merges each item and
// drives the output word register plus a one-word hold. Depends on lbp_pkg.
`default_nettype none

module lbp_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lbp_pkg::item_t                item_i,
  input  wire lbp_pkg::q_stat_t              q_stat_i,
  output logic                               pop_o,
  output logic                               m_valid_o,
  input  wire logic                          m_ready_i,
  output logic [lbp_pkg::WORD_BITS-1:0]      m_word_o,
  output logic [lbp_pkg::VBITS_W-1:0]        m_vbits_o,
  output logic                               m_last_o,
  output logic                               hold_valid_o
);
  import lbp_pkg::*;

  logic [WORD_BITS-1:0] pend_bits_q;
  logic [PCOUNT_W-1:0]  pend_cnt_q;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] out_word_q;
  logic [VBITS_W-1:0]   out_vbits_q;
  logic                 out_last_q;
  logic                 hold_valid_q;
  logic [WORD_BITS-1:0] hold_word_q;

  logic                 out_free;
  logic [ACC_BITS-1:0]  acc;
  logic [COUNT_W-1:0]   total;
  logic [1:0]           n_words;

  assign out_free = !out_valid_q || m_ready_i;
  assign pop_o    = !q_stat_i.empty && !hold_valid_q && out_free;

  always_comb begin
    acc     = ({{WORD_BITS{1'b0}}, item_i.bits} << pend_cnt_q)
              | ACC_BITS'(pend_bits_q);
    total   = COUNT_W'(pend_cnt_q) + item_i.count;
    n_words = total[COUNT_W-1:PCOUNT_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q  <= '0;
      pend_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      if (hold_valid_q && out_free) begin
        // Advance the second word of a two-word append.
        out_valid_q  <= 1'b1;
        hold_valid_q <= 1'b0;
      end else if (pop_o) begin
        if (item_i.kind == CMD_FLUSH) begin
          out_valid_q <= (pend_cnt_q != '0);
          pend_bits_q <= '0;
          pend_cnt_q  <= '0;
        end else begin
          out_valid_q  <= (n_words != 2'd0);
          hold_valid_q <= (n_words == 2'd2);
          pend_cnt_q   <= total[PCOUNT_W-1:0];
          case (n_words)
            2'd0:    pend_bits_q <= acc[WORD_BITS-1:0];
            2'd1:    pend_bits_q <= acc[2*WORD_BITS-1:WORD_BITS];
            default: pend_bits_q <= acc[3*WORD_BITS-1:2*WORD_BITS];
          endcase
        end
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (hold_valid_q && out_free) begin
      out_word_q  <= hold_word_q;
      out_vbits_q <= FULL_VBITS;
      out_last_q  <= 1'b1;
    end else if (pop_o) begin
      if (item_i.kind == CMD_FLUSH) begin
        out_word_q  <= pend_bits_q;
        out_vbits_q <= VBITS_W'(pend_cnt_q);
        out_last_q  <= 1'b1;
      end else begin
        out_word_q  <= acc[WORD_BITS-1:0];
        out_vbits_q <= FULL_VBITS;
        out_last_q  <= (n_words == 2'd1);
        hold_word_q <= acc[2*WORD_BITS-1:WORD_BITS];
      end
    end
  end

  assign m_valid_o    = out_valid_q;
  assign m_word_o     = out_word_q;
  assign m_vbits_o    = out_vbits_q;
  assign m_last_o     = out_last_q;
  assign hold_valid_o = hold_valid_q;

endmodule

`default_nettype wire

[rtl/lsb_first_bit_packer.sv]
// LSB-first bit packer: top level wiring front, queue and back end.
// Depends on lbp_pkg, lbp_front, lbp_queue and lbp_back.
//
// Usage:
//   The slave channel takes one word per item. tuser selects the command:
//   append (0) adds the low bit_count bits of code_value (counts above 64
//   saturate to 64) after the pending bits; flush (1) emits the zero-padded
//   partial word, if any, and restarts the stream at bit position zero.
//   The master channel returns 32-bit packed words, earliest bit in bit 0,
//   with valid_bits (32, or 1 to 31 on a flush) and tlast on the final word
//   that an item causes. An append emits zero, one or two words.
//   An accepted item is written into the queue; once it is at the queue
//   head and the back end is free, it is merged and its first word is
//   registered in the output word register. Throughput: one item per
//   cycle when it completes at most one word and the master side does not
//   stall; an item that completes two words blocks the next item until its
//   second word moves from the hold into the single output word register.
//   A two-entry queue sits between the front and the back, so the slave
//   side keeps taking items while a finished word waits on a stalled
//   master side; once the queue fills, s_axis_tready drops.
//   Reset clears the pending bits, the queue and the output and hold valid flags.
`default_nettype none

module lsb_first_bit_packer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: [63:0] code_value, [70:64] bit_count, [71] zero padding
  input  wire logic [lbp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: [0] command
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: [31:0] packed_word, [37:32] valid_bits, [39:38] zero padding
  output logic [lbp_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast
);
  import lbp_pkg::*;

  item_t                push_item, head_item;
  q_stat_t              q_stat;
  logic                 push, pop;
  logic [WORD_BITS-1:0] out_word;
  logic [VBITS_W-1:0]   out_vbits;
  logic                 hold_valid;

  // Classify and mask incoming words.
  lbp_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_user_i  (s_axis_tuser),
    .s_code_i  (s_axis_tdata[CODE_BITS-1:0]),
    .s_count_i (s_axis_tdata[CODE_BITS+COUNT_W-1:CODE_BITS]),
    .s_ready_o (s_axis_tready),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .item_o    (push_item)
  );

  // Hold items until the back end is free.
  lbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  // Merge bits into the pending word and emit completed words.
  lbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_word_o     (out_word),
    .m_vbits_o    (out_vbits),
    .m_last_o     (m_axis_tlast),
    .hold_valid_o (hold_valid)
  );

  assign m_axis_tdata = {{(M_TDATA_W-WORD_BITS-VBITS_W){1'b0}}, out_vbits, out_word};

  // A held second word always has its first word in the output register.
  a_hold_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid |-> m_axis_tvalid)
    else $error("second word held without a first word on the output");

  // A word that is not the last of its item is always a full word.
  a_nonlast_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (out_vbits == FULL_VBITS))
    else $error("non-final word with partial valid_bits");

  // An emitted word carries between 1 and 32 valid bits.
  a_vbits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_vbits != '0) && (out_vbits <= FULL_VBITS)))
    else $error("valid_bits out of range");

  // The back end never pops while a second word is still held.
  a_no_pop_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid |-> !pop)
    else $error("item popped while a word is held");

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for lsb_first_bit_packer: directed table, then random codes.
// Depends on lbp_pkg and the lsb_first_bit_packer RTL; needs no other file.
`default_nettype none

module testbench;
  import lbp_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AT_ITEM = 300;

  // One packed word as the master side returns it.
  typedef struct packed {
    logic [WORD_BITS-1:0] data;
    logic [VBITS_W-1:0]   vbits;
    logic                 last;
  } word_t;

  // Directed stimulus row. Rows with hand_typed set carry their own expected
  // words; the rest are checked against the predictor.
  typedef struct packed {
    cmd_e                 cmd;
    logic [CODE_BITS-1:0] value;
    logic [COUNT_W-1:0]   count;
    logic                 hand_typed;
    logic [1:0]           n_words;
    logic [WORD_BITS-1:0] w0;
    logic [VBITS_W-1:0]   v0;
    logic [WORD_BITS-1:0] w1;
  } stim_row_t;

  localparam int N_ROWS = 21;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // flush right after reset: nothing pending, so no word
    '{CMD_FLUSH,  64'h0, 7'd0, 1'b1, 2'd0, 32'h0, 6'd0, 32'h0},
    // zero-bit append changes nothing
    '{CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b1, 2'd0, 32'h0, 6'd0, 32'h0},
    // one full word from an empty position
    '{CMD_APPEND, 64'h0000_0000_DEAD_BEEF, 7'd32, 1'b1, 2'd1, 32'hDEAD_BEEF, 6'd32, 32'h0},
    // 64-bit code completes two words, low half first
    '{CMD_APPEND, 64'h0123_4567_89AB_CDEF, 7'd64, 1'b1, 2'd2,
      32'h89AB_CDEF, 6'd32, 32'h0123_4567},
    // count of 127 saturates to 64
    '{CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1, 2'd2,
      32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF},
    '{CMD_APPEND, 64'h1, 7'd1, 1'b1, 2'd0, 32'h0, 6'd0, 32'h0},
    // one-bit partial word
    '{CMD_FLUSH,  64'h0, 7'd0, 1'b1, 2'd1, 32'h1, 6'd1, 32'h0},
    '{CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd31, 1'b1, 2'd0, 32'h0, 6'd0, 32'h0},
    // 31 pending plus 64 new: two words, 31 bits left over
    '{CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 1'b1, 2'd2,
      32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF},
    // widest partial word
    '{CMD_FLUSH,  64'h0, 7'd0, 1'b1, 2'd1, 32'h7FFF_FFFF, 6'd31, 32'h0},
    '{CMD_APPEND, 64'h5555_5555_5555_5555, 7'd65, 1'b0, 2'd0, 32'h0, 6'd0, 32'h0},
    '{CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFD, 7'd3, 1'b0, 2'd0, 32'h0, 6'd0, 32'h0},
    '{CMD_APPEND, 64'hC3A5_0F96_1E2D_3C4B, 7'd33, 1'b0, 2'd0, 32'h0, 6'd0, 32'h0},
    '{CMD_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, 2'd0, 32'h0, 6'd0, 32'h0},
    '{CMD_FLUSH,  64'h0, 7'd0, 1'b1, 2'd0, 32'h0, 6'd0, 32'h0},
    '{CMD_APPEND, 64'h0, 7'd64, 1'b1, 2'd2, 32'h0, 6'd32, 32'h0},
    '{CMD_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 7'd96, 1'b0, 2'd0, 32'h0, 6'd0, 32'h0},
    '{CMD_APPEND, 64'h8000_0000_0000_0000, 7'd17, 1'b0, 2'd0, 32'h0, 6'd0, 32'h0},
    '{CMD_FLUSH,  64'h0, 7'd0, 1'b0, 2'd0, 32'h0, 6'd0, 32'h0},
    '{CMD_APPEND, 64'h0, 7'd1, 1'b1, 2'd0, 32'h0, 6'd0, 32'h0},
    // a flushed zero bit still counts as one valid bit
    '{CMD_FLUSH,  64'h0, 7'd0, 1'b1, 2'd1, 32'h0, 6'd1, 32'h0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  lsb_first_bit_packer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predictor state: bits not yet packed into a word, LSB first.
  logic [WORD_BITS-1:0] pend_bits;
  int                   pend_cnt;

  word_t words_due[$];    // expected words, oldest first
  word_t fresh_words[$];  // words the latest item completes

  int  errors = 0;
  int  n_cycles = 0;
  int  n_words_seen = 0;
  int  n_partials = 0;
  int  n_appends, n_flushes;
  bit  hold_req = 1'b0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog: end the run with a failure once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Work out the words one item completes and advance the pending bits.
  task automatic pack_code(input cmd_e cmd, input logic [CODE_BITS-1:0] value,
                           input logic [COUNT_W-1:0] count);
    logic [ACC_BITS-1:0]  acc;
    logic [CODE_BITS-1:0] masked;
    int                   nbits;
    int                   total;
    int                   n_full;
    fresh_words.delete();
    if (cmd == CMD_FLUSH) begin
      if (pend_cnt != 0)
        fresh_words.push_back('{pend_bits, VBITS_W'(pend_cnt), 1'b1});
      pend_bits = '0;
      pend_cnt  = 0;
    end else begin
      // saturate the count, then drop code bits above it
      nbits  = (count > MAX_COUNT) ? CODE_BITS : int'(count);
      masked = (nbits == CODE_BITS) ? value : value & ((64'd1 << nbits) - 64'd1);
      acc    = (ACC_BITS'(masked) << pend_cnt) | ACC_BITS'(pend_bits);
      total  = pend_cnt + nbits;
      n_full = total / WORD_BITS;
      for (int i = 0; i < n_full; i++)
        fresh_words.push_back('{acc[i*WORD_BITS +: WORD_BITS], FULL_VBITS,
                                i == n_full - 1});
      pend_bits = WORD_BITS'(acc >> (n_full * WORD_BITS));
      pend_cnt  = total % WORD_BITS;
    end
  endtask

  // Offer one item from the falling edge on and hold it until accepted.
  // Returns right after the accepting rising edge.
  task automatic offer_item(input cmd_e cmd, input logic [CODE_BITS-1:0] value,
                            input logic [COUNT_W-1:0] count, input logic pad);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {pad, count, value};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_FLUSH) n_flushes++;
    else n_appends++;
  endtask

  // Idle the slave side for the given number of falling edges.
  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: stretches of steady ready, stretches of jitter, and one long
  // hold-off on request so the queue fills and tready drops on the slave side.
  initial begin : receiver
    int quiet_left;
    int phase_left;
    bit jitter;
    bit hold_done;
    quiet_left = 0;
    phase_left = 0;
    jitter     = 1'b0;
    hold_done  = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        jitter     = $urandom_range(0, 2) != 0;
        phase_left = $urandom_range(100, 300);
      end
      phase_left--;
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        quiet_left = HOLD_CYCLES;
      end else if (quiet_left == 0 && jitter) begin
        if ($urandom_range(0, 99) < 25) quiet_left = $urandom_range(1, 3);
        else if ($urandom_range(0, 99) < 2) quiet_left = $urandom_range(10, 40);
      end
      if (quiet_left > 0) begin
        m_axis_tready <= 1'b0;
        quiet_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Checker: compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_words_seen++;
      if (m_axis_tdata[WORD_BITS +: VBITS_W] != FULL_VBITS) n_partials++;
      if (words_due.size() == 0) begin
        $error("unexpected word: packed_word %h valid_bits %0d last %b",
               m_axis_tdata[WORD_BITS-1:0], m_axis_tdata[WORD_BITS +: VBITS_W],
               m_axis_tlast);
        errors++;
      end else begin
        want = words_due.pop_front();
        if (m_axis_tdata[WORD_BITS-1:0] !== want.data) begin
          $error("packed_word: expected %h, got %h", want.data,
                 m_axis_tdata[WORD_BITS-1:0]);
          errors++;
        end
        if (m_axis_tdata[WORD_BITS +: VBITS_W] !== want.vbits) begin
          $error("valid_bits: expected %0d, got %0d", want.vbits,
                 m_axis_tdata[WORD_BITS +: VBITS_W]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t            row;
    cmd_e                 cmd;
    logic [CODE_BITS-1:0] value;
    logic [COUNT_W-1:0]   count;
    int                   r;
    n_appends     = 0;
    n_flushes     = 0;
    pend_bits     = '0;
    pend_cnt      = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= CMD_APPEND;
    s_axis_tdata  <= '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: edges of the count, saturation, empty flushes and the
    // widest partial word. Hand-typed rows still advance the predictor.
    for (int i = 0; i < N_ROWS; i++) begin
      row = DIRECTED[i];
      offer_item(row.cmd, row.value, row.count, 1'b0);
      pack_code(row.cmd, row.value, row.count);
      if (row.hand_typed) begin
        if (row.n_words == 2'd1) begin
          words_due.push_back('{row.w0, row.v0, 1'b1});
        end else if (row.n_words == 2'd2) begin
          words_due.push_back('{row.w0, FULL_VBITS, 1'b0});
          words_due.push_back('{row.w1, FULL_VBITS, 1'b1});
        end
      end else begin
        foreach (fresh_words[k]) words_due.push_back(fresh_words[k]);
      end
      idle_sender(pick_gap());
    end

    // Random codes. Every third block of items runs with no sender gaps.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      cmd   = ($urandom_range(0, 99) < 12) ? CMD_FLUSH : CMD_APPEND;
      value = {$urandom, $urandom};
      r     = $urandom_range(0, 99);
      if (r < 5) count = 7'd0;
      else if (r < 15) count = MAX_COUNT;
      else if (r < 25) count = COUNT_W'($urandom_range(65, 127));
      else if (r < 50) count = COUNT_W'($urandom_range(1, 8));
      else count = COUNT_W'($urandom_range(1, 63));
      r = $urandom_range(0, 19);
      if (r == 0) value = '1;
      else if (r == 1) value = '0;
      // Ask for the long receiver hold-off and keep offering meanwhile.
      if (i == HOLD_AT_ITEM) hold_req = 1'b1;
      offer_item(cmd, value, count, 1'($urandom_range(0, 1)));
      pack_code(cmd, value, count);
      foreach (fresh_words[k]) words_due.push_back(fresh_words[k]);
      if ((i / 128) % 3 != 0 && !(i >= HOLD_AT_ITEM && i < HOLD_AT_ITEM + 64))
        idle_sender(pick_gap());
    end

    // Drain: wait for every expected word, then keep watching for stray words.
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d appends and %0d flushes sent, %0d words checked (%0d partial)",
             n_appends, n_flushes, n_words_seen, n_partials);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
